// File: rtl/sst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg
// Types and codes shared by the two-scope symbol table modules.
// ----------------------------------------------------------------------------
package sst_pkg;

    // item codes
    localparam logic [2:0] MODE_DEFINE      = 3'd0;
    localparam logic [2:0] MODE_LOOKUP      = 3'd1;
    localparam logic [2:0] MODE_COUNT       = 3'd2;
    localparam logic [2:0] MODE_CLEAR_SUB   = 3'd3;
    localparam logic [2:0] MODE_CLEAR_CLASS = 3'd4;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    localparam logic [1:0] KIND_STATIC = 2'd0;
    localparam logic [1:0] KIND_FIELD  = 2'd1;
    localparam logic [1:0] KIND_ARG    = 2'd2;
    localparam logic [1:0] KIND_LOCAL  = 2'd3;

    // fixed field widths
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int TYPE_W  = 16;
    localparam int KEY_W   = 64;

    typedef struct packed {
        logic [2:0]        mode;
        logic [KEY_W-1:0]  name_key;
        logic [TYPE_W-1:0] type_code;
        logic [1:0]        kind;
    } req_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [1:0]        kind_out;
        logic [IDX_W-1:0]  index_out;
        logic [TYPE_W-1:0] type_out;
        logic [CNT_W-1:0]  count_out;
    } rsp_item_t;

    // control from the sequencer to one scope
    typedef struct packed {
        logic clear;
        logic wr_en;
        logic scan_run;
    } scope_cmd_t;

    // status from one scope back to the sequencer
    typedef struct packed {
        logic full;
        logic hit;
        logic done;
    } scope_sts_t;

endpackage

// File: rtl/sst_scope.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_scope
// One scope: entry memory, fill level and a linear scan for a key, one read
// per cycle with a registered read port.
// ----------------------------------------------------------------------------
module sst_scope #(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 64,
    parameter int TW       = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sst_pkg::scope_cmd_t   cmd,
    output sst_pkg::scope_sts_t   sts,
    input  logic [KEY_BITS-1:0]   wr_key,
    input  logic [TW-1:0]         wr_type,
    input  logic                  wr_kind,
    input  logic [sst_pkg::IDX_W-1:0] wr_index,
    input  logic [KEY_BITS-1:0]   scan_key,
    output logic [TW-1:0]         hit_type,
    output logic                  hit_kind,
    output logic [sst_pkg::IDX_W-1:0] hit_index
);
    import sst_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int WIDTH = KEY_BITS + TW + 1 + IDX_W;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] ptr_reg, ptr_next;
    logic          pend_reg, pend_next;
    logic          rd_en;
    logic          match;
    logic [KEY_BITS-1:0] rd_key;

    // unpack the registered read word
    assign rd_key    = rd_data_reg[WIDTH-1 -: KEY_BITS];
    assign hit_type  = rd_data_reg[IDX_W+1 +: TW];
    assign hit_kind  = rd_data_reg[IDX_W];
    assign hit_index = rd_data_reg[IDX_W-1:0];

    // scan control: one read issued per cycle below the fill level
    assign match = pend_reg && (rd_key == scan_key);
    assign rd_en = cmd.scan_run && (ptr_reg < fill_reg) && !match;

    assign sts.full = (fill_reg == FW'(DEPTH));
    assign sts.hit  = cmd.scan_run && match;
    assign sts.done = cmd.scan_run && (match || (!pend_reg && (ptr_reg >= fill_reg)));

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.clear)
        begin
            fill_next = '0;
        end
        else if (cmd.wr_en)
        begin
            fill_next = fill_reg + FW'(1);
        end
        if (cmd.scan_run)
        begin
            ptr_next  = rd_en ? ptr_reg + FW'(1) : ptr_reg;
            pend_next = rd_en;
        end
        else
        begin
            ptr_next  = '0;
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            ptr_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            ptr_reg  <= ptr_next;
            pend_reg <= pend_next;
        end
    end

    // entry memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[fill_reg[AW-1:0]] <= {wr_key, wr_type, wr_kind, wr_index};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[ptr_reg[AW-1:0]];
        end
    end

endmodule

// File: rtl/sst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_ctrl
// Item sequencer: decodes the mode, keeps the per-kind counters, runs the
// inner then outer scan for a lookup and holds the result register.
// ----------------------------------------------------------------------------
module sst_ctrl #(
    parameter int OUTER_DEPTH = 64,
    parameter int INNER_DEPTH = 64,
    parameter int KEY_BITS    = 64,
    parameter int TW          = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  sst_pkg::req_item_t    req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output sst_pkg::rsp_item_t    rsp,
    output sst_pkg::scope_cmd_t   o_cmd,
    input  sst_pkg::scope_sts_t   o_sts,
    output sst_pkg::scope_cmd_t   i_cmd,
    input  sst_pkg::scope_sts_t   i_sts,
    output logic [KEY_BITS-1:0]   wr_key,
    output logic [TW-1:0]         wr_type,
    output logic                  wr_kind,
    output logic [sst_pkg::IDX_W-1:0] wr_index,
    output logic [KEY_BITS-1:0]   scan_key,
    input  logic [TW-1:0]         o_hit_type,
    input  logic                  o_hit_kind,
    input  logic [sst_pkg::IDX_W-1:0] o_hit_index,
    input  logic [TW-1:0]         i_hit_type,
    input  logic                  i_hit_kind,
    input  logic [sst_pkg::IDX_W-1:0] i_hit_index
);
    import sst_pkg::*;

    localparam int MAX_DEPTH = (OUTER_DEPTH > INNER_DEPTH) ? OUTER_DEPTH : INNER_DEPTH;
    localparam int CW        = $clog2(MAX_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_INNER = 4'b0010,
        S_OUTER = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg [4];
    logic [CW-1:0]       cnt_next [4];
    logic [KEY_BITS-1:0] key_reg, key_next;
    rsp_item_t           res_reg, res_next;
    rsp_item_t           rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic                accept;
    logic                scope_full;
    logic                done_load;
    logic [CW-1:0]       cur_cnt;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign done_load = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    // write data comes from the accepted item; the index from its kind's counter
    assign wr_key   = req.name_key[KEY_BITS-1:0];
    assign wr_type  = req.type_code[TW-1:0];
    assign wr_kind  = req.kind[0];
    assign cur_cnt  = cnt_reg[req.kind];
    assign wr_index = IDX_W'(cur_cnt);
    assign scan_key = key_reg;

    assign scope_full = req.kind[1] ? i_sts.full : o_sts.full;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        res_next   = res_reg;
        for (int k = 0; k < 4; k++)
        begin
            cnt_next[k] = cnt_reg[k];
        end
        o_cmd = '0;
        i_cmd = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next   = '0;
                    state_next = S_DONE;
                    case (req.mode)
                        MODE_DEFINE:
                        begin
                            if (scope_full)
                            begin
                                res_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                if (req.kind[1])
                                begin
                                    i_cmd.wr_en = 1'b1;
                                end
                                else
                                begin
                                    o_cmd.wr_en = 1'b1;
                                end
                                cnt_next[req.kind]  = cur_cnt + CW'(1);
                                res_next.status    = STATUS_OK;
                                res_next.kind_out  = req.kind;
                                res_next.index_out = IDX_W'(cur_cnt);
                                res_next.type_out  = TYPE_W'(req.type_code[TW-1:0]);
                            end
                        end
                        MODE_LOOKUP:
                        begin
                            key_next   = req.name_key[KEY_BITS-1:0];
                            state_next = S_INNER;
                        end
                        MODE_COUNT:
                        begin
                            res_next.kind_out  = req.kind;
                            res_next.count_out = CNT_W'(cur_cnt);
                        end
                        MODE_CLEAR_SUB:
                        begin
                            i_cmd.clear       = 1'b1;
                            cnt_next[KIND_ARG]   = '0;
                            cnt_next[KIND_LOCAL] = '0;
                        end
                        MODE_CLEAR_CLASS:
                        begin
                            o_cmd.clear        = 1'b1;
                            cnt_next[KIND_STATIC] = '0;
                            cnt_next[KIND_FIELD]  = '0;
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            S_INNER:
            begin
                i_cmd.scan_run = 1'b1;
                if (i_sts.hit)
                begin
                    res_next.status    = STATUS_OK;
                    res_next.kind_out  = {1'b1, i_hit_kind};
                    res_next.index_out = i_hit_index;
                    res_next.type_out  = TYPE_W'(i_hit_type);
                    state_next         = S_DONE;
                end
                else if (i_sts.done)
                begin
                    state_next = S_OUTER;
                end
            end
            S_OUTER:
            begin
                o_cmd.scan_run = 1'b1;
                if (o_sts.hit)
                begin
                    res_next.status    = STATUS_OK;
                    res_next.kind_out  = {1'b0, o_hit_kind};
                    res_next.index_out = o_hit_index;
                    res_next.type_out  = TYPE_W'(o_hit_type);
                    state_next         = S_DONE;
                end
                else if (o_sts.done)
                begin
                    res_next.status = STATUS_NOT_FOUND;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (done_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register toward the consumer
    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (done_load)
        begin
            rsp_next       = res_reg;
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            for (int k = 0; k < 4; k++)
            begin
                cnt_reg[k] <= cnt_next[k];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

endmodule

// File: rtl/scoped_symbol_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scoped_symbol_table_unit
// Two-scope symbol table: class scope (static, field) and subroutine scope
// (argument, local), each in its own entry memory, with per-kind indexes.
// ----------------------------------------------------------------------------
//  channel | signals                   | direction | payload
//  --------+---------------------------+-----------+---------------------
//  req     | req_valid, req_ready      | in        | sst_pkg::req_item_t
//  rsp     | rsp_valid, rsp_ready      | out       | sst_pkg::rsp_item_t
//
//  define, count, clear, unused modes: res_reg, then the output register.
//  lookup: one memory read per entry per cycle, inner scope first; it
//  stops at the first match.
//  one item in flight at a time; req_ready is low until its result is
//  loaded into the output register, which holds it while rsp_ready is low.
//  reset empties both scopes and the kind counters; no memory sweep.
// ----------------------------------------------------------------------------
module scoped_symbol_table_unit #(
    parameter int OUTER_DEPTH = 64,
    parameter int INNER_DEPTH = 64,
    parameter int KEY_BITS    = 64,
    parameter int TYPE_BITS   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  sst_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output sst_pkg::rsp_item_t rsp
);
    import sst_pkg::*;

    // stored type width: the port carries at most TYPE_W bits
    localparam int TW = (TYPE_BITS < TYPE_W) ? TYPE_BITS : TYPE_W;

    scope_cmd_t          o_cmd, i_cmd;
    scope_sts_t          o_sts, i_sts;
    logic [KEY_BITS-1:0] wr_key, scan_key;
    logic [TW-1:0]       wr_type, o_hit_type, i_hit_type;
    logic                wr_kind, o_hit_kind, i_hit_kind;
    logic [IDX_W-1:0]    wr_index, o_hit_index, i_hit_index;

    // item sequencer and result register
    sst_ctrl #(
        .OUTER_DEPTH (OUTER_DEPTH),
        .INNER_DEPTH (INNER_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .TW          (TW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .o_cmd       (o_cmd),
        .o_sts       (o_sts),
        .i_cmd       (i_cmd),
        .i_sts       (i_sts),
        .wr_key      (wr_key),
        .wr_type     (wr_type),
        .wr_kind     (wr_kind),
        .wr_index    (wr_index),
        .scan_key    (scan_key),
        .o_hit_type  (o_hit_type),
        .o_hit_kind  (o_hit_kind),
        .o_hit_index (o_hit_index),
        .i_hit_type  (i_hit_type),
        .i_hit_kind  (i_hit_kind),
        .i_hit_index (i_hit_index)
    );

    // class scope
    sst_scope #(
        .DEPTH    (OUTER_DEPTH),
        .KEY_BITS (KEY_BITS),
        .TW       (TW)
    ) u_outer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (o_cmd),
        .sts       (o_sts),
        .wr_key    (wr_key),
        .wr_type   (wr_type),
        .wr_kind   (wr_kind),
        .wr_index  (wr_index),
        .scan_key  (scan_key),
        .hit_type  (o_hit_type),
        .hit_kind  (o_hit_kind),
        .hit_index (o_hit_index)
    );

    // subroutine scope
    sst_scope #(
        .DEPTH    (INNER_DEPTH),
        .KEY_BITS (KEY_BITS),
        .TW       (TW)
    ) u_inner (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (i_cmd),
        .sts       (i_sts),
        .wr_key    (wr_key),
        .wr_type   (wr_type),
        .wr_kind   (wr_kind),
        .wr_index  (wr_index),
        .scan_key  (scan_key),
        .hit_type  (i_hit_type),
        .hit_kind  (i_hit_kind),
        .hit_index (i_hit_index)
    );

endmodule
